@@ rtl/uyvy_pkg.sv @@
`default_nettype none
package uyvy_pkg;

	typedef enum logic [3:0] {
		PH_U  = 4'b0001,
		PH_Y0 = 4'b0010,
		PH_V  = 4'b0100,
		PH_Y1 = 4'b1000
	} phase_t;

	localparam logic FMT_RGB888 = 1'b0;
	localparam logic FMT_RGB565 = 1'b1;

	// fixed-point coefficients, scaled by 256
	localparam logic [7:0] K_R_V = 8'd103;
	localparam logic [7:0] K_G_U = 8'd88;
	localparam logic [7:0] K_G_V = 8'd183;
	localparam logic [7:0] K_B_U = 8'd198;

	typedef logic [23:0] pixel_t;

	// floor(c * k / 256) as an arithmetic shift of the full product
	function automatic logic signed [8:0] scale_floor(logic signed [7:0] c, logic [7:0] k);
		logic signed [16:0] prod;
		prod = $signed({{9{c[7]}}, c}) * $signed({9'b0, k});
		return prod[16:8];
	endfunction

	function automatic logic [7:0] clamp8(logic signed [10:0] x);
		logic [7:0] res;
		if (x[10]) begin
			res = 8'd0;
		end else if (x[9:8] != 2'b00) begin
			res = 8'hFF;
		end else begin
			res = x[7:0];
		end
		return res;
	endfunction

	function automatic pixel_t pack_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic fmt);
		pixel_t word;
		if (fmt == FMT_RGB565) begin
			word = {8'd0, r[7:3], g[7:2], b[7:3]};
		end else begin
			word = {r, g, b};
		end
		return word;
	endfunction

endpackage
`default_nettype wire

@@ rtl/uyvy_cfg_if.sv @@
`default_nettype none
interface uyvy_cfg_if;
	logic valid;
	logic ready;
	logic output_format;

	modport source(output valid, output output_format, input ready);
	modport sink(input valid, input output_format, output ready);
endinterface
`default_nettype wire

@@ rtl/uyvy_in_if.sv @@
`default_nettype none
interface uyvy_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source(output valid, output data_byte, output frame_start, input ready);
	modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface
`default_nettype wire

@@ rtl/uyvy_out_if.sv @@
`default_nettype none
interface uyvy_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface
`default_nettype wire

@@ rtl/uyvy_to_rgb_pixel_converter.sv @@
// a V or second Y byte is registered in the operand stage, its pixel then in the result stage
// throughput: one byte per cycle unless rgb stalls, one pixel per two bytes; U and first Y give no pixel
// the byte phase and operands sit in one register stage, conversion in the next
// reset clears the byte phase, held U/V/Y, output format and both valid bits
`default_nettype none
module uyvy_to_rgb_pixel_converter
	import uyvy_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	uyvy_cfg_if.sink      cfg,
	uyvy_in_if.sink       stream,
	uyvy_out_if.source    rgb
);

	logic       fmt_q;
	phase_t     phase_q;
	phase_t     phase_cur;
	phase_t     phase_nxt;
	logic [7:0] held_u_q;
	logic [7:0] held_v_q;
	logic [7:0] held_y_q;

	logic       valid_s1;
	logic [7:0] y_s1;
	logic [7:0] u_s1;
	logic [7:0] v_s1;

	logic       pix_valid_q;
	pixel_t     pix_q;

	logic       out_free;
	logic       s1_free;
	logic       in_beat;
	logic       emit;
	logic [7:0] op_y;
	logic [7:0] op_v;

	logic signed [7:0]  u_c;
	logic signed [7:0]  v_c;
	logic signed [10:0] r_sum;
	logic signed [10:0] g_sum;
	logic signed [10:0] b_sum;
	pixel_t             pix_d;

	assign cfg.ready = 1'b1;

	assign out_free     = !pix_valid_q || rgb.ready;
	assign s1_free      = !valid_s1 || out_free;
	assign stream.ready = s1_free;
	assign in_beat      = stream.valid && s1_free;

	assign phase_cur = stream.frame_start ? PH_U : phase_q;

	always_comb begin
		phase_nxt = PH_U;
		emit      = 1'b0;
		op_y      = held_y_q;
		op_v      = held_v_q;
		case (phase_cur)
			PH_U: begin
				phase_nxt = PH_Y0;
			end
			PH_Y0: begin
				phase_nxt = PH_V;
			end
			PH_V: begin
				phase_nxt = PH_Y1;
				emit      = 1'b1;
				op_v      = stream.data_byte;
			end
			PH_Y1: begin
				phase_nxt = PH_U;
				emit      = 1'b1;
				op_y      = stream.data_byte;
			end
			default: begin
				phase_nxt = PH_U;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB888;
		end else if (cfg.valid) begin
			fmt_q <= cfg.output_format;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_U;
			held_u_q <= 8'd0;
			held_v_q <= 8'd0;
			held_y_q <= 8'd0;
		end else if (in_beat) begin
			phase_q <= phase_nxt;
			if (phase_cur == PH_U) begin
				held_u_q <= stream.data_byte;
			end
			if (phase_cur == PH_Y0) begin
				held_y_q <= stream.data_byte;
			end
			if (phase_cur == PH_V) begin
				held_v_q <= stream.data_byte;
			end
		end
	end

	// operand stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_beat && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && emit) begin
			y_s1 <= op_y;
			u_s1 <= held_u_q;
			v_s1 <= op_v;
		end
	end

	// chroma minus 128 is the byte with its top bit flipped
	assign u_c = $signed({~u_s1[7], u_s1[6:0]});
	assign v_c = $signed({~v_s1[7], v_s1[6:0]});

	always_comb begin
		logic signed [8:0] f_rv;
		logic signed [8:0] f_gu;
		logic signed [8:0] f_gv;
		logic signed [8:0] f_bu;
		f_rv  = scale_floor(v_c, K_R_V);
		f_gu  = scale_floor(u_c, K_G_U);
		f_gv  = scale_floor(v_c, K_G_V);
		f_bu  = scale_floor(u_c, K_B_U);
		r_sum = $signed({3'b000, y_s1}) + $signed({{3{v_c[7]}}, v_c})
			+ $signed({{2{f_rv[8]}}, f_rv});
		g_sum = $signed({3'b000, y_s1}) - $signed({{2{f_gu[8]}}, f_gu})
			- $signed({{2{f_gv[8]}}, f_gv});
		b_sum = $signed({3'b000, y_s1}) + $signed({{3{u_c[7]}}, u_c})
			+ $signed({{2{f_bu[8]}}, f_bu});
		pix_d = pack_pixel(clamp8(r_sum), clamp8(g_sum), clamp8(b_sum), fmt_q);
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (out_free) begin
			pix_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			pix_q <= pix_d;
		end
	end

	assign rgb.valid = pix_valid_q;
	assign rgb.pixel = pix_q;

endmodule
`default_nettype wire

@@ rtl/uyvy_chk.sv @@
`default_nettype none
module uyvy_chk
	import uyvy_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        cfg_format,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_frame_start,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [23:0] out_pixel
);

	logic fmt_q;
	logic in_beat;

	assign in_beat = in_valid && in_ready;

	// shadow of the format register, seen from the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB888;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= cfg_format;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel))
		else $error("pixel beat dropped or changed while stalled");

	a_565_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fmt_q == FMT_RGB565 |-> out_pixel[23:16] == 8'd0)
		else $error("rgb565 pixel has upper byte set");

	a_rise_from_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_beat, 2))
		else $error("pixel appeared without a byte two cycles earlier");

	a_start_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && in_frame_start |-> ##2 !$rose(out_valid))
		else $error("frame start byte produced a pixel");

endmodule

bind uyvy_to_rgb_pixel_converter uyvy_chk u_uyvy_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.cfg_valid      (cfg.valid),
	.cfg_ready      (cfg.ready),
	.cfg_format     (cfg.output_format),
	.in_valid       (stream.valid),
	.in_ready       (stream.ready),
	.in_frame_start (stream.frame_start),
	.out_valid      (rgb.valid),
	.out_ready      (rgb.ready),
	.out_pixel      (rgb.pixel)
);
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
module tb_top;
	import uyvy_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PHASES = 6;
	localparam int BYTES_PER_PHASE = 215;

	typedef enum logic {ROW_BYTE, ROW_FMT} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [7:0] data;   // stream byte, or new format on a format row
		logic       fs;
		logic       typed;
		pixel_t     px;
	} script_row_t;

	// hand-checked values only for neutral chroma; the rest goes through the predictor
	localparam script_row_t SCRIPT [25] = '{
		'{ROW_BYTE, 8'h80, 1'b1, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h80, 1'b0, 1'b1, 24'h000000},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 24'hFFFFFF},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h12, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h34, 1'b0, 1'b0, 24'h000000},
		// frame start where V was due: pair dropped
		'{ROW_BYTE, 8'h80, 1'b1, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h10, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h80, 1'b0, 1'b1, 24'h101010},
		// frame start where second Y was due
		'{ROW_BYTE, 8'h80, 1'b1, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h20, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h80, 1'b0, 1'b1, 24'h202020},
		'{ROW_FMT,  8'(FMT_RGB565), 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h80, 1'b1, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 24'h000000},
		'{ROW_BYTE, 8'h80, 1'b0, 1'b1, 24'h00FFFF},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b1, 24'h000000}
	};

	logic clk;
	logic arst_n;

	uyvy_cfg_if cfg_bus();
	uyvy_in_if  byte_bus();
	uyvy_out_if rgb_bus();

	uyvy_to_rgb_pixel_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.stream (byte_bus),
		.rgb    (rgb_bus)
	);

	// predictor state
	phase_t     exp_phase;
	logic [7:0] hold_u;
	logic [7:0] hold_v;
	logic [7:0] hold_y;
	logic       cur_fmt;

	pixel_t expected_pixels[$];
	int     mismatch_cnt;
	int     bytes_sent;
	logic   idle_on;
	logic   beat_typed;
	pixel_t beat_typed_px;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int chroma_floor(int c, int k);
		return (c * k) >>> 8;
	endfunction

	function automatic logic [7:0] sat_byte(int x);
		if (x < 0) begin
			return 8'd0;
		end else if (x > 255) begin
			return 8'd255;
		end
		return 8'(x);
	endfunction

	function automatic pixel_t rgb_from_yuv(logic [7:0] y, logic [7:0] u, logic [7:0] v,
			logic fmt);
		int yi;
		int ui;
		int vi;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		yi = int'(y);
		ui = int'(u) - 128;
		vi = int'(v) - 128;
		r = sat_byte(yi + vi + chroma_floor(vi, int'(K_R_V)));
		g = sat_byte(yi - chroma_floor(ui, int'(K_G_U)) - chroma_floor(vi, int'(K_G_V)));
		b = sat_byte(yi + ui + chroma_floor(ui, int'(K_B_U)));
		if (fmt == FMT_RGB565) begin
			return {8'd0, r[7:3], g[7:2], b[7:3]};
		end
		return {r, g, b};
	endfunction

	task automatic step_stream(input logic [7:0] data, input logic fs, output logic hit,
			output pixel_t px);
		hit = 1'b0;
		px = '0;
		if (fs) begin
			exp_phase = PH_U;
		end
		case (exp_phase)
			PH_Y0: begin
				hold_y = data;
				exp_phase = PH_V;
			end
			PH_V: begin
				hold_v = data;
				px = rgb_from_yuv(hold_y, hold_u, data, cur_fmt);
				hit = 1'b1;
				exp_phase = PH_Y1;
			end
			PH_Y1: begin
				px = rgb_from_yuv(data, hold_u, hold_v, cur_fmt);
				hit = 1'b1;
				exp_phase = PH_U;
			end
			default: begin
				hold_u = data;
				exp_phase = PH_Y0;
			end
		endcase
	endtask

	task automatic log_mismatch(input string what, input pixel_t want, input pixel_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("mismatch (%s): expected %06h got %06h", what, want, got);
		end
	endtask

	// monitor: predictor runs on accepted bytes, checker on accepted pixels
	always @(posedge clk) begin : monitor
		logic   hit;
		pixel_t px;
		pixel_t want;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				cur_fmt = cfg_bus.output_format;
			end
			if (byte_bus.valid && byte_bus.ready) begin
				step_stream(byte_bus.data_byte, byte_bus.frame_start, hit, px);
				if (hit) begin
					expected_pixels.push_back(beat_typed ? beat_typed_px : px);
				end
			end
			if (rgb_bus.valid && rgb_bus.ready) begin
				if (expected_pixels.size() == 0) begin
					log_mismatch("no pixel pending", '0, rgb_bus.pixel);
				end else begin
					want = expected_pixels.pop_front();
					if (rgb_bus.pixel !== want) begin
						log_mismatch("pixel", want, rgb_bus.pixel);
					end
				end
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// sink side stalls
	initial begin : sink_stall
		int stall_left;
		stall_left = 0;
		rgb_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rgb_bus.ready = 1'b0;
				stall_left--;
			end else begin
				rgb_bus.ready = 1'b1;
				if (idle_on && $urandom_range(0, 4) == 0) begin
					stall_left = gap_len();
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("uyvy_to_rgb_pixel_converter verification failed");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_byte(input logic [7:0] data, input logic fs, input logic typed,
			input pixel_t typed_px);
		int gap;
		gap = idle_on ? gap_len() : 0;
		if (gap > 0) begin
			byte_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_bus.valid = 1'b1;
		byte_bus.data_byte = data;
		byte_bus.frame_start = fs;
		beat_typed = typed;
		beat_typed_px = typed_px;
		do begin
			@(posedge clk);
		end while (!byte_bus.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// hold off the stream until every pending pixel is out
	task automatic settle_stream();
		byte_bus.valid = 1'b0;
		beat_typed = 1'b0;
		while (expected_pixels.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_format(input logic fmt);
		settle_stream();
		cfg_bus.valid = 1'b1;
		cfg_bus.output_format = fmt;
		do begin
			@(posedge clk);
		end while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// a run of UYVY pairs, sometimes without a frame start, sometimes cut short
	task automatic send_frame();
		int pairs;
		int p;
		int k;
		int cut;
		logic broken;
		logic marked;
		pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
		broken = ($urandom_range(0, 9) == 0);
		marked = ($urandom_range(0, 7) != 0);
		cut = $urandom_range(1, 3);
		for (p = 0; p < pairs; p++) begin
			for (k = 0; k < 4; k++) begin
				if (broken && p == pairs - 1 && k == cut) begin
					return;
				end
				send_byte(rand_byte(), marked && p == 0 && k == 0, 1'b0, '0);
			end
		end
	endtask

	initial begin : stimulus
		logic fmt_plan [RANDOM_PHASES];
		int i;
		int ph;
		fmt_plan = '{FMT_RGB888, FMT_RGB565, FMT_RGB888, FMT_RGB565, FMT_RGB565, FMT_RGB888};
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.output_format = FMT_RGB888;
		byte_bus.valid = 1'b0;
		byte_bus.data_byte = 8'h00;
		byte_bus.frame_start = 1'b0;
		beat_typed = 1'b0;
		beat_typed_px = '0;
		idle_on = 1'b1;
		mismatch_cnt = 0;
		bytes_sent = 0;
		exp_phase = PH_U;
		hold_u = 8'h00;
		hold_v = 8'h00;
		hold_y = 8'h00;
		cur_fmt = FMT_RGB888;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < $size(SCRIPT); i++) begin
			if (SCRIPT[i].kind == ROW_FMT) begin
				write_format(SCRIPT[i].data[0]);
			end else begin
				send_byte(SCRIPT[i].data, SCRIPT[i].fs, SCRIPT[i].typed, SCRIPT[i].px);
			end
		end

		bytes_sent = 0;
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_format(fmt_plan[ph]);
			idle_on = (ph != 2);
			while (bytes_sent < (ph + 1) * BYTES_PER_PHASE) begin
				if (ph == 3 && bytes_sent >= ph * BYTES_PER_PHASE + BYTES_PER_PHASE / 2 &&
						bytes_sent < ph * BYTES_PER_PHASE + BYTES_PER_PHASE / 2 + 4) begin
					settle_stream();
				end
				if ($urandom_range(0, 19) == 0) begin
					// stray byte, sometimes with a frame start of its own
					send_byte(rand_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
				end else begin
					send_frame();
				end
			end
		end

		settle_stream();
		repeat (10) @(negedge clk);
		if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
			$display("uyvy_to_rgb_pixel_converter verification clean");
		end else begin
			$display("uyvy_to_rgb_pixel_converter verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
